FILE: hdl/ksc_pkg.sv
`default_nettype none

package ksc_pkg;

    // Slot table depth, fixed by the 6-bit slot number
    localparam int SLOT_DEPTH = 64;
    localparam int SLOT_W     = 6;
    localparam int STEP_W     = 3;

    typedef enum logic [1:0] {
        CMD_GENO = 2'd0,
        CMD_KIN  = 2'd1,
        CMD_SLOT = 2'd2,
        CMD_RUN  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        CLS_NONE = 2'd0,
        CLS_GENO = 2'd1,
        CLS_REL  = 2'd2,
        CLS_VIA  = 2'd3
    } cls_t;

    typedef enum logic [1:0] {
        BR_NEXT      = 2'd0,
        BR_LOOP_DOWN = 2'd1,
        BR_LOOP_UP   = 2'd2,
        BR_STOP      = 2'd3
    } br_t;

    localparam logic [STEP_W-1:0] STEP_SLOT_RD = 3'd0;
    localparam logic [STEP_W-1:0] STEP_ROW_RD  = 3'd1;
    localparam logic [STEP_W-1:0] STEP_EVAL    = 3'd2;
    localparam logic [STEP_W-1:0] STEP_CLS_RD  = 3'd3;
    localparam logic [STEP_W-1:0] STEP_EMIT    = 3'd4;

    typedef struct packed {
        logic              slot_rd;
        logic              rel_rd;
        logic              cls_wr;
        logic              cls_rd;
        logic              emit;
        br_t               br;
        logic [STEP_W-1:0] target;
    } ctrl_t;

    typedef struct packed {
        logic idx_nz;
        logic last;
    } status_t;

    // Microprogram: downward evaluation pass, then upward result pass
    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        ctrl_t c;
        begin
            c = '0;
            unique case (step)
                STEP_SLOT_RD:
                begin
                    c.slot_rd = 1'b1;
                    c.br      = BR_NEXT;
                end
                STEP_ROW_RD:
                begin
                    c.rel_rd = 1'b1;
                    c.br     = BR_NEXT;
                end
                STEP_EVAL:
                begin
                    c.cls_wr = 1'b1;
                    c.br     = BR_LOOP_DOWN;
                    c.target = STEP_SLOT_RD;
                end
                STEP_CLS_RD:
                begin
                    c.cls_rd = 1'b1;
                    c.br     = BR_NEXT;
                end
                STEP_EMIT:
                begin
                    c.emit   = 1'b1;
                    c.br     = BR_LOOP_UP;
                    c.target = STEP_CLS_RD;
                end
                default:
                begin
                    c.br = BR_STOP;
                end
            endcase
            return c;
        end
    endfunction

endpackage

`default_nettype wire

FILE: hdl/kinship_subset_classifier_core.sv
`default_nettype none

// Kinship subset classifier.
// Command port: a word is taken at a clock edge with start high and busy low.
//   cmd 0 sets one person's genotyped flag, cmd 1 writes one kinship entry
//   (only "above zero" is kept), cmd 2 maps a phenotyped slot to a person.
//   Load words keep busy low, so they may stream back to back, one per
//   cycle while no run holds busy.
//   cmd 3 runs the classification of pheno_count slots (saturated at 64).
// A run raises busy at the next edge and walks the slots downwards, each
//   slot by slot table read, kinship row read and evaluate, then walks
//   them upwards, each result by class table read and emit. A run with
//   pheno_count 0 yields nothing and busy never rises. The pace is set by
//   the registered reads of the slot, kinship and class memories in the
//   microprogram loop; a new command is taken only once busy has dropped.
// Results: result_strobe marks slot_out/subset_class/last for one cycle,
//   in slot order, last high on the final one. The receiver cannot stall;
//   busy drops on the edge that ends the last result.
// Reset clears the genotyped flags and the sequencer. The kinship and slot
//   tables are undefined until written; there is no clearing pass.
module kinship_subset_classifier_core #(
    parameter int MAX_PEOPLE   = 64,
    parameter int KINSHIP_BITS = 16
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [1:0]              cmd,
    input  wire logic [5:0]              row_index,
    input  wire logic [5:0]              column_index,
    input  wire logic [5:0]              pheno_slot,
    input  wire logic                    genotyped,
    input  wire logic [KINSHIP_BITS-1:0] kinship_value,
    input  wire logic [6:0]              people_count,
    input  wire logic [6:0]              pheno_count,
    output logic                         result_strobe,
    output logic [5:0]                   slot_out,
    output logic [1:0]                   subset_class,
    output logic                         last
);

    import ksc_pkg::*;

    // person indices are 6 bits wide, so at most one slot table's worth
    localparam int PEOPLE = (MAX_PEOPLE < SLOT_DEPTH) ? MAX_PEOPLE : SLOT_DEPTH;

    logic    accept, run_go;
    ctrl_t   ctrl;
    status_t status;

    assign accept = start && !busy;
    assign run_go = accept && cmd == CMD_RUN && pheno_count != '0;

    ksc_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .run_go (run_go),
        .status (status),
        .ctrl   (ctrl),
        .busy   (busy)
    );

    ksc_datapath #(.PEOPLE(PEOPLE), .KINSHIP_BITS(KINSHIP_BITS)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .run_go        (run_go),
        .ctrl          (ctrl),
        .cmd           (cmd),
        .row_index     (row_index),
        .column_index  (column_index),
        .pheno_slot    (pheno_slot),
        .genotyped     (genotyped),
        .kinship_value (kinship_value),
        .people_count  (people_count),
        .pheno_count   (pheno_count),
        .status        (status),
        .slot_out      (slot_out),
        .subset_class  (subset_class)
    );

    assign result_strobe = ctrl.emit;
    assign last          = status.last;

    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> busy)
        else $error("result outside a run");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && last |=> !busy)
        else $error("run continues past last result");

    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("run began without a command");

    a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |=> !result_strobe)
        else $error("results closer than two cycles");

endmodule

`default_nettype wire

FILE: hdl/ksc_ram.sv
`default_nettype none

module ksc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [WIDTH-1:0]         wmask,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // bit-masked write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            for (int b = 0; b < WIDTH; b++)
            begin
                if (wmask[b])
                begin
                    mem_reg[waddr][b] <= wdata[b];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hdl/ksc_sequencer.sv
`default_nettype none

module ksc_sequencer (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             run_go,
    input  wire ksc_pkg::status_t status,
    output ksc_pkg::ctrl_t        ctrl,
    output logic                  busy
);

    import ksc_pkg::*;

    logic [STEP_W-1:0] pc_reg, pc_next;
    logic              busy_reg, busy_next;
    ctrl_t             word;

    assign word = ucode(pc_reg);
    assign ctrl = busy_reg ? word : '0;
    assign busy = busy_reg;

    always_comb
    begin
        pc_next   = pc_reg;
        busy_next = busy_reg;
        if (run_go)
        begin
            pc_next   = STEP_SLOT_RD;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            unique case (word.br)
                BR_NEXT:
                begin
                    pc_next = pc_reg + 1'b1;
                end
                BR_LOOP_DOWN:
                begin
                    pc_next = status.idx_nz ? word.target : pc_reg + 1'b1;
                end
                BR_LOOP_UP:
                begin
                    if (status.last)
                    begin
                        pc_next   = STEP_SLOT_RD;
                        busy_next = 1'b0;
                    end
                    else
                    begin
                        pc_next = word.target;
                    end
                end
                default:
                begin
                    pc_next   = STEP_SLOT_RD;
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= STEP_SLOT_RD;
            busy_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            busy_reg <= busy_next;
        end
    end

    // step counter only ever sits on a programmed step while running
    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (pc_reg <= STEP_EMIT))
        else $error("sequencer off program");

endmodule

`default_nettype wire

FILE: hdl/ksc_datapath.sv
`default_nettype none

module ksc_datapath #(
    parameter int PEOPLE       = 64,
    parameter int KINSHIP_BITS = 16
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    accept,
    input  wire logic                    run_go,
    input  wire ksc_pkg::ctrl_t          ctrl,
    input  wire logic [1:0]              cmd,
    input  wire logic [5:0]              row_index,
    input  wire logic [5:0]              column_index,
    input  wire logic [5:0]              pheno_slot,
    input  wire logic                    genotyped,
    input  wire logic [KINSHIP_BITS-1:0] kinship_value,
    input  wire logic [6:0]              people_count,
    input  wire logic [6:0]              pheno_count,
    output ksc_pkg::status_t             status,
    output logic [5:0]                   slot_out,
    output logic [1:0]                   subset_class
);

    import ksc_pkg::*;

    localparam int PW = $clog2(PEOPLE);

    logic [PEOPLE-1:0] geno_reg, geno_next;
    logic [PEOPLE-1:0] later_reg, later_next;
    logic [PEOPLE-1:0] mask_reg, mask_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic [SLOT_W-1:0] emit_reg, emit_next;
    logic [6:0]        npheno_reg, npheno_next;

    logic              row_ok, col_ok, kin_pos;
    logic [6:0]        npheno_sat;
    logic [SLOT_W-1:0] person;
    logic              in_range;
    logic [PEOPLE-1:0] rel_rdata, row;
    logic              own_geno, rel_geno, via_later;
    cls_t              cls;
    logic [1:0]        cls_rdata;

    assign row_ok  = 32'(row_index) < PEOPLE;
    assign col_ok  = 32'(column_index) < PEOPLE;
    assign kin_pos = !kinship_value[KINSHIP_BITS-1] && (kinship_value != '0);

    assign npheno_sat = (pheno_count > 7'(SLOT_DEPTH)) ? 7'(SLOT_DEPTH) : pheno_count;

    ksc_ram #(.WIDTH(PEOPLE), .DEPTH(PEOPLE)) u_rel_ram (
        .clk   (clk),
        .we    (accept && cmd == CMD_KIN && row_ok && col_ok),
        .waddr (row_index[PW-1:0]),
        .wdata ({PEOPLE{kin_pos}}),
        .wmask (PEOPLE'(1'b1) << column_index[PW-1:0]),
        .re    (ctrl.rel_rd),
        .raddr (person[PW-1:0]),
        .rdata (rel_rdata)
    );

    ksc_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_DEPTH)) u_slot_ram (
        .clk   (clk),
        .we    (accept && cmd == CMD_SLOT),
        .waddr (pheno_slot),
        .wdata (row_index),
        .wmask ({SLOT_W{1'b1}}),
        .re    (ctrl.slot_rd),
        .raddr (idx_reg),
        .rdata (person)
    );

    ksc_ram #(.WIDTH(2), .DEPTH(SLOT_DEPTH)) u_cls_ram (
        .clk   (clk),
        .we    (ctrl.cls_wr),
        .waddr (idx_reg),
        .wdata (2'(cls)),
        .wmask (2'b11),
        .re    (ctrl.cls_rd),
        .raddr (emit_reg),
        .rdata (cls_rdata)
    );

    // slot table output holds through the evaluate step
    assign in_range  = 32'(person) < PEOPLE;
    assign row       = in_range ? rel_rdata : '0;
    assign own_geno  = in_range && geno_reg[person[PW-1:0]];
    assign rel_geno  = |(row & geno_reg & mask_reg);
    assign via_later = |(row & later_reg);

    always_comb
    begin
        if (own_geno)
        begin
            cls = CLS_GENO;
        end
        else if (rel_geno)
        begin
            cls = CLS_REL;
        end
        else if (via_later)
        begin
            cls = CLS_VIA;
        end
        else
        begin
            cls = CLS_NONE;
        end
    end

    always_comb
    begin
        geno_next   = geno_reg;
        later_next  = later_reg;
        mask_next   = mask_reg;
        idx_next    = idx_reg;
        emit_next   = emit_reg;
        npheno_next = npheno_reg;
        if (accept && cmd == CMD_GENO && row_ok)
        begin
            geno_next[row_index[PW-1:0]] = genotyped;
        end
        if (run_go)
        begin
            later_next  = '0;
            idx_next    = SLOT_W'(npheno_sat - 7'd1);
            emit_next   = '0;
            npheno_next = npheno_sat;
            for (int k = 0; k < PEOPLE; k++)
            begin
                mask_next[k] = 32'(people_count) > k;
            end
        end
        if (ctrl.cls_wr)
        begin
            idx_next = idx_reg - 1'b1;
            if (rel_geno)
            begin
                later_next = later_reg | (PEOPLE'(1'b1) << person[PW-1:0]);
            end
        end
        if (ctrl.emit)
        begin
            emit_next = emit_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            geno_reg   <= '0;
            later_reg  <= '0;
            mask_reg   <= '0;
            idx_reg    <= '0;
            emit_reg   <= '0;
            npheno_reg <= '0;
        end
        else
        begin
            geno_reg   <= geno_next;
            later_reg  <= later_next;
            mask_reg   <= mask_next;
            idx_reg    <= idx_next;
            emit_reg   <= emit_next;
            npheno_reg <= npheno_next;
        end
    end

    assign status.idx_nz = idx_reg != '0;
    assign status.last   = ({1'b0, emit_reg} + 7'd1) == npheno_reg;
    assign slot_out      = emit_reg;
    assign subset_class  = cls_rdata;

endmodule

`default_nettype wire
